// ----- hw/rtl/lms_pkg.sv -----
// lms_pkg: shared constants, types and state codes for the
// longest monotone subsequence length block; no dependencies
`default_nettype none
package lms_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int DATA_W          = 32;
  localparam int RES_LEN_W       = 11;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 32;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [CFG_ADDR_W-1:0] ADDR_ORDER_MODE = 3'd0;

  localparam logic MODE_NON_INCREASING = 1'b0;
  localparam logic MODE_INCREASING     = 1'b1;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic                     last;
  } q_entry_t;

  typedef struct packed {
    logic     avail;
    q_entry_t entry;
  } q_head_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEARCH,
    ST_RESULT
  } eng_state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/lms_if.sv -----
// lms_in_if, lms_out_if: valid/ready channels for input and result words
// depends on lms_pkg
`default_nettype none
interface lms_in_if
  import lms_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sample_value;
  logic                     last_of_sequence;

  modport source (output valid, sample_value, last_of_sequence, input ready);
  modport sink   (input valid, sample_value, last_of_sequence, output ready);
endinterface

interface lms_out_if
  import lms_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [RES_LEN_W-1:0] current_length;
  logic                 table_full_drop;
  logic                 final_result;

  modport source (output valid, current_length, table_full_drop, final_result,
                  input ready);
  modport sink   (input valid, current_length, table_full_drop, final_result,
                  output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/lms_queue.sv -----
// lms_queue: front end, accepts input words into a short queue
// depends on lms_pkg and lms_in_if
`default_nettype none
module lms_queue
  import lms_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  lms_in_if.sink      in_word,
  output q_head_t     head,
  input  wire logic   pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t           slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               push;
  logic               do_pop;

  assign in_word.ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign push          = in_word.valid && in_word.ready;
  assign do_pop        = pop && (count_r != '0);

  assign head.avail = (count_r != '0);
  assign head.entry = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= '{sample: in_word.sample_value, last: in_word.last_of_sequence};
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/lms_engine.sv -----
// lms_engine: back end, tail table memory, binary search sequencer and
// result register; depends on lms_pkg and lms_out_if
`default_nettype none
module lms_engine
  import lms_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    order_mode,
  input  wire q_head_t head,
  output logic         pop,
  lms_out_if.source    out_word
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int LEN_W  = $clog2(TABLE_DEPTH + 1);

  logic signed [DATA_W-1:0] tail_mem [TABLE_DEPTH];
  logic signed [DATA_W-1:0] rd_data_r;

  eng_state_t               state_r, state_nxt;
  logic signed [DATA_W-1:0] v_r, v_nxt;
  logic                     last_r, last_nxt;
  logic                     drop_r, drop_nxt;
  logic [LEN_W-1:0]         len_r, len_nxt;
  logic [ADDR_W-1:0]        lo_r, lo_nxt;
  logic [ADDR_W-1:0]        hi_r, hi_nxt;
  logic [ADDR_W-1:0]        mid_r, mid_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [RES_LEN_W-1:0]     out_len_r, out_len_nxt;
  logic                     out_drop_r, out_drop_nxt;
  logic                     out_last_r, out_last_nxt;

  logic                     rd_en, wr_en;
  logic [ADDR_W-1:0]        rd_addr, wr_addr;
  logic signed [DATA_W-1:0] wr_data;

  logic                     keep;
  logic [LEN_W-1:0]         len_dec;
  logic [ADDR_W-1:0]        len_m1;
  logic [ADDR_W-1:0]        lo_n, hi_n, span_n, mid_n;
  logic                     slot_free;
  logic [LEN_W+RES_LEN_W-1:0] len_ext;

  // datapath helpers shared by both control blocks
  always_comb begin
    keep      = (order_mode == MODE_INCREASING) ? (rd_data_r < v_r) : (rd_data_r >= v_r);
    len_dec   = len_r - 1'b1;
    len_m1    = len_dec[ADDR_W-1:0];
    lo_n      = keep ? (mid_r + 1'b1) : lo_r;
    hi_n      = keep ? hi_r : mid_r;
    span_n    = hi_n - lo_n;
    mid_n     = lo_n + (span_n >> 1);
    slot_free = !out_valid_r || out_word.ready;
    len_ext   = {{RES_LEN_W{1'b0}}, len_r};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (head.avail) begin
          state_nxt = (len_r == '0) ? ST_RESULT : ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = (keep || (len_m1 == '0)) ? ST_RESULT : ST_SEARCH;
      end
      ST_SEARCH: begin
        state_nxt = (lo_n < hi_n) ? ST_SEARCH : ST_RESULT;
      end
      ST_RESULT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pop           = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = v_r;
    v_nxt         = v_r;
    last_nxt      = last_r;
    drop_nxt      = drop_r;
    len_nxt       = len_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    out_valid_nxt = out_valid_r && !out_word.ready;
    out_len_nxt   = out_len_r;
    out_drop_nxt  = out_drop_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (head.avail) begin
          pop      = 1'b1;
          v_nxt    = head.entry.sample;
          last_nxt = head.entry.last;
          drop_nxt = 1'b0;
          if (len_r == '0) begin
            wr_en   = 1'b1;
            wr_data = head.entry.sample;
            len_nxt = LEN_W'(1);
          end else begin
            rd_en   = 1'b1;
            rd_addr = len_m1;
          end
        end
      end
      ST_CHECK: begin
        if (keep) begin
          if (len_r < LEN_W'(TABLE_DEPTH)) begin
            wr_en   = 1'b1;
            wr_addr = len_r[ADDR_W-1:0];
            len_nxt = len_r + 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
        end else if (len_m1 == '0) begin
          wr_en = 1'b1;
        end else begin
          lo_nxt  = '0;
          hi_nxt  = len_m1;
          mid_nxt = len_m1 >> 1;
          rd_en   = 1'b1;
          rd_addr = len_m1 >> 1;
        end
      end
      ST_SEARCH: begin
        lo_nxt = lo_n;
        hi_nxt = hi_n;
        if (lo_n < hi_n) begin
          mid_nxt = mid_n;
          rd_en   = 1'b1;
          rd_addr = mid_n;
        end else begin
          wr_en   = 1'b1;
          wr_addr = lo_n;
        end
      end
      ST_RESULT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_len_nxt   = len_ext[RES_LEN_W-1:0];
          out_drop_nxt  = drop_r;
          out_last_nxt  = last_r;
          if (last_r) begin
            len_nxt = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    last_r     <= last_nxt;
    drop_r     <= drop_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    out_len_r  <= out_len_nxt;
    out_drop_r <= out_drop_nxt;
    out_last_r <= out_last_nxt;
  end

  // tail table, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tail_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= tail_mem[rd_addr];
    end
  end

  assign out_word.valid           = out_valid_r;
  assign out_word.current_length  = out_len_r;
  assign out_word.table_full_drop = out_drop_r;
  assign out_word.final_result    = out_last_r;

endmodule
`default_nettype wire

// ----- hw/rtl/longest_monotone_subsequence_length.sv -----
// longest_monotone_subsequence_length: top level, mode register, queue and engine
// depends on lms_pkg, lms_if, lms_queue and lms_engine
//
//  channel   role    width         notes
//  in_word   sink    32 + 1        sample_value, last_of_sequence
//  out_word  source  11 + 1 + 1    current_length, table_full_drop, final_result
//  psel..    apb     3 addr, 32    order_mode at byte address 0
//
// a word into an empty table is written at once; else the last tail is read and
// checked; an append or a one-entry table is written, else a binary search runs
// with one registered tail memory read per step; a two-entry queue takes words
// while the engine works, a finished result waits in the output register without
// blocking the queue; reset clears the length and the mode, tails need no clearing
`default_nettype none
module longest_monotone_subsequence_length
  import lms_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  lms_in_if.sink                     in_word,
  lms_out_if.source                  out_word,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  logic    order_mode_r, order_mode_nxt;
  q_head_t head;
  logic    pop;

  assign pready = 1'b1;

  always_comb begin
    order_mode_nxt = order_mode_r;
    if (psel && penable && pwrite && (paddr == ADDR_ORDER_MODE)) begin
      order_mode_nxt = pwdata[0];
    end
    prdata = '0;
    if (paddr == ADDR_ORDER_MODE) begin
      prdata = {{(CFG_DATA_W-1){1'b0}}, order_mode_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_mode_r <= MODE_NON_INCREASING;
    end else begin
      order_mode_r <= order_mode_nxt;
    end
  end

  lms_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_word (in_word),
    .head    (head),
    .pop     (pop)
  );

  lms_engine #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .order_mode (order_mode_r),
    .head       (head),
    .pop        (pop),
    .out_word   (out_word)
  );

endmodule
`default_nettype wire
